// ----- hdl/atl_pkg.sv -----
// ----------------------------------------------------------------------------
// atl_pkg
// Shared types and constants of the assembler token lexer: token kinds,
// number error codes, the token record and the push bundle that the lexer
// core hands to the token queue.
// ----------------------------------------------------------------------------
package atl_pkg;

    // Default width of the position and length counters
    localparam int POSITION_BITS_DEFAULT = 32;

    // Entries of the token queue in front of the output port
    localparam int TOKEN_FIFO_DEPTH = 4;

    typedef enum logic [3:0] {
        KIND_INVALID = 4'd0,
        KIND_EOF     = 4'd1,
        KIND_IDENT   = 4'd2,
        KIND_MINUS   = 4'd3,
        KIND_NUMBER  = 4'd4,
        KIND_BADNUM  = 4'd5,
        KIND_COMMA   = 4'd6,
        KIND_DOT     = 4'd7,
        KIND_COLON   = 4'd8,
        KIND_COMMENT = 4'd9,
        KIND_NEWLINE = 4'd10
    } t_kind;

    typedef enum logic [1:0] {
        NERR_NONE      = 2'd0,
        NERR_OVERFLOW  = 2'd1,
        NERR_BAD_DIGIT = 2'd2,
        NERR_NO_DIGITS = 2'd3
    } t_num_err;

    // One token as it leaves the block
    typedef struct packed {
        t_kind       kind;
        logic [31:0] start;
        logic [31:0] length;
        logic [63:0] value;
        t_num_err    err;
        logic        last;
    } t_token;

    // Tokens produced by one input beat, first in order, count 0 to 2
    typedef struct packed {
        logic [1:0] count;
        t_token     first;
        t_token     second;
    } t_push;

endpackage

// ----- hdl/assembler_token_lexer.sv -----
// ----------------------------------------------------------------------------
// assembler_token_lexer
// Streaming lexer for assembly source text: bytes in, tokens out.
// ----------------------------------------------------------------------------
// The block takes one source byte or an end-of-input command per beat and
// returns tokens (kind, start, length, number value and error), the last token
// of each input beat flagged by o_last_result. It accepts one input beat per
// clock as long as each beat yields at most one token and the output does not
// stall; a beat that closes a pending token and also yields a fresh one (or end
// of input with a pending token) puts two tokens in the four-entry output queue,
// which drains one token per output beat, so a run of such beats stalls the
// byte side. A token reaches the output through the input register and then
// the output queue. Position and length counters are POSITION_BITS wide and
// wrap; the ports carry their low 32 bits.
// ----------------------------------------------------------------------------
module assembler_token_lexer
    import atl_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [7:0]  i_source_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_token_kind,
    output logic [31:0] o_token_start,
    output logic [31:0] o_token_length,
    output logic [63:0] o_number_value,
    output logic [1:0]  o_number_error,
    output logic        o_last_result
);

    logic       r_in_vld;
    logic       r_in_cmd;
    logic [7:0] r_in_byte;
    logic       w_room;
    logic       w_fire;
    logic       w_accept;
    t_push      w_push;
    t_token     w_head;

    // Move the held beat into the core when the queue can take two tokens
    assign w_fire   = r_in_vld && w_room;
    assign o_stall  = r_in_vld && !w_room;
    assign w_accept = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= w_accept || (r_in_vld && !w_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_cmd  <= i_command;
            r_in_byte <= i_source_byte;
        end
    end

    atl_lexer_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_command     (r_in_cmd),
        .i_source_byte (r_in_byte),
        .o_push        (w_push)
    );

    atl_token_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_head  (w_head),
        .o_room  (w_room)
    );

    // Drive the output fields from the queue head
    assign o_token_kind   = w_head.kind;
    assign o_token_start  = w_head.start;
    assign o_token_length = w_head.length;
    assign o_number_value = w_head.value;
    assign o_number_error = w_head.err;
    assign o_last_result  = w_head.last;

    // A held beat that cannot enter the core stays put
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_room) |=> (r_in_vld && $stable(r_in_cmd) && $stable(r_in_byte)))
        else $error("held input beat lost or changed while the core was blocked");

    // End of input always yields at least the end-of-file token
    a_eof_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_cmd) |-> (w_push.count != 2'd0))
        else $error("end of input produced no token");

    // Only the second of two tokens carries the last flag
    a_last_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.count == 2'd2) |-> (!w_push.first.last && w_push.second.last))
        else $error("last flag misplaced on a two-token beat");

    // No tokens appear without a beat entering the core
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |-> (w_push.count == 2'd0))
        else $error("tokens pushed without an input beat");

endmodule

// ----- hdl/atl_lexer_core.sv -----
// ----------------------------------------------------------------------------
// atl_lexer_core
// Scanner state and the single-pass next-state logic. For each input beat it
// closes the pending token if the byte ends it, lexes the byte afresh when
// needed, and presents up to two tokens in order.
// ----------------------------------------------------------------------------
module atl_lexer_core
    import atl_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic       i_command,
    input  logic [7:0] i_source_byte,
    output t_push      o_push
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_ZERO,
        MODE_NUMBER,
        MODE_COMMENT,
        MODE_CR
    } t_mode;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_HEX,
        RADIX_OCT,
        RADIX_BIN
    } t_radix;

    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_B    = 8'h42;
    localparam logic [7:0] CH_UPPER_D    = 8'h44;
    localparam logic [7:0] CH_UPPER_O    = 8'h4F;
    localparam logic [7:0] CH_UPPER_X    = 8'h58;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CASE_MASK     = 8'hDF;
    localparam logic [7:0] LETTER_BIAS   = 8'h37;

    localparam logic [POSITION_BITS-1:0] PLEN_ZERO = POSITION_BITS'(0);
    localparam logic [POSITION_BITS-1:0] PLEN_ONE  = POSITION_BITS'(1);
    localparam logic [POSITION_BITS-1:0] PLEN_TWO  = POSITION_BITS'(2);

    t_mode                    r_mode,  n_mode;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [POSITION_BITS-1:0] r_len,   n_len;
    logic [POSITION_BITS-1:0] r_pos,   n_pos;
    logic [63:0]              r_acc,   n_acc;
    t_radix                   r_radix, n_radix;
    logic                     r_seen,  n_seen;

    logic [7:0]  w_upper;
    logic        w_is_digit;
    logic        w_is_letter;
    logic        w_is_ident;
    logic [7:0]  w_dval_full;
    logic [5:0]  w_dval;
    logic [5:0]  w_base;
    logic [67:0] w_scaled;
    logic [67:0] w_sum;
    logic        w_overflow;
    logic        w_relex;
    logic        w_num_path;
    logic        w_e0_vld;
    logic        w_e1_vld;
    t_token      w_e0;
    t_token      w_e1;

    function automatic t_token mk_tok(
        input t_kind                    kind,
        input logic [POSITION_BITS-1:0] start,
        input logic [POSITION_BITS-1:0] len,
        input logic [63:0]              value,
        input t_num_err                 err
    );
        t_token tok;
        tok.kind   = kind;
        tok.start  = 32'(start);
        tok.length = 32'(len);
        tok.value  = value;
        tok.err    = err;
        tok.last   = 1'b0;
        return tok;
    endfunction

    // Classify the byte and find its digit value
    always_comb begin
        w_upper     = i_source_byte & CASE_MASK;
        w_is_digit  = (i_source_byte >= CH_ZERO) && (i_source_byte <= CH_NINE);
        w_is_letter = (w_upper >= CH_UPPER_A) && (w_upper <= CH_UPPER_Z);
        w_is_ident  = w_is_digit || w_is_letter || (i_source_byte == CH_UNDERSCORE);
        w_dval_full = w_is_digit ? (i_source_byte - CH_ZERO) : (w_upper - LETTER_BIAS);
        w_dval      = w_dval_full[5:0];
    end

    // Shift-add of the accumulator for the current base, with overflow flag
    always_comb begin
        unique case (r_radix)
            RADIX_HEX: begin
                w_base   = 6'd16;
                w_scaled = {r_acc, 4'b0000};
            end
            RADIX_OCT: begin
                w_base   = 6'd8;
                w_scaled = {1'b0, r_acc, 3'b000};
            end
            RADIX_BIN: begin
                w_base   = 6'd2;
                w_scaled = {3'b000, r_acc, 1'b0};
            end
            default: begin
                w_base   = 6'd10;
                w_scaled = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0};
            end
        endcase
        w_sum      = w_scaled + 68'(w_dval);
        w_overflow = |w_sum[67:64];
    end

    // Next state and emitted tokens for one beat
    always_comb begin
        n_mode     = r_mode;
        n_start    = r_start;
        n_len      = r_len;
        n_pos      = r_pos;
        n_acc      = r_acc;
        n_radix    = r_radix;
        n_seen     = r_seen;
        w_relex    = 1'b0;
        w_num_path = 1'b0;
        w_e0_vld   = 1'b0;
        w_e1_vld   = 1'b0;
        w_e0       = '0;
        w_e1       = '0;

        if (i_fire && i_command) begin
            // flush the pending token, then end of input
            unique case (r_mode)
                MODE_IDENT: begin
                    w_e0_vld = 1'b1;
                    w_e0 = mk_tok(KIND_IDENT, r_start, r_len, 64'd0, NERR_NONE);
                end
                MODE_ZERO, MODE_NUMBER: begin
                    w_e0_vld = 1'b1;
                    if (r_seen) begin
                        w_e0 = mk_tok(KIND_NUMBER, r_start, r_len, r_acc, NERR_NONE);
                    end else begin
                        w_e0 = mk_tok(KIND_BADNUM, r_start, r_len, 64'd0, NERR_NO_DIGITS);
                    end
                end
                MODE_COMMENT: begin
                    w_e0_vld = 1'b1;
                    w_e0 = mk_tok(KIND_COMMENT, r_start, r_len, 64'd0, NERR_NONE);
                end
                MODE_CR: begin
                    w_e0_vld = 1'b1;
                    w_e0 = mk_tok(KIND_NEWLINE, r_start, PLEN_ONE, 64'd0, NERR_NONE);
                end
                default: begin
                end
            endcase
            w_e1_vld = 1'b1;
            w_e1     = mk_tok(KIND_EOF, r_pos, PLEN_ZERO, 64'd0, NERR_NONE);
            n_mode   = MODE_IDLE;
            n_start  = PLEN_ZERO;
            n_len    = PLEN_ZERO;
            n_pos    = PLEN_ZERO;
            n_acc    = 64'd0;
            n_radix  = RADIX_DEC;
            n_seen   = 1'b0;
        end else if (i_fire) begin
            n_pos = r_pos + PLEN_ONE;

            // extend or close the pending token
            unique case (r_mode)
                MODE_IDENT: begin
                    if (w_is_ident) begin
                        n_len = r_len + PLEN_ONE;
                    end else begin
                        w_e0_vld = 1'b1;
                        w_e0 = mk_tok(KIND_IDENT, r_start, r_len, 64'd0, NERR_NONE);
                        w_relex = 1'b1;
                    end
                end
                MODE_COMMENT: begin
                    if (i_source_byte != CH_LF && i_source_byte != CH_CR) begin
                        n_len = r_len + PLEN_ONE;
                    end else begin
                        w_e0_vld = 1'b1;
                        w_e0 = mk_tok(KIND_COMMENT, r_start, r_len, 64'd0, NERR_NONE);
                        w_relex = 1'b1;
                    end
                end
                MODE_CR: begin
                    n_mode   = MODE_IDLE;
                    w_e0_vld = 1'b1;
                    if (i_source_byte == CH_LF) begin
                        w_e0 = mk_tok(KIND_NEWLINE, r_start, PLEN_TWO, 64'd0, NERR_NONE);
                    end else begin
                        w_e0 = mk_tok(KIND_NEWLINE, r_start, PLEN_ONE, 64'd0, NERR_NONE);
                        w_relex = 1'b1;
                    end
                end
                MODE_ZERO: begin
                    n_mode = MODE_NUMBER;
                    n_len  = PLEN_TWO;
                    n_acc  = 64'd0;
                    n_seen = 1'b0;
                    unique case (w_upper)
                        CH_UPPER_X: n_radix = RADIX_HEX;
                        CH_UPPER_D: n_radix = RADIX_DEC;
                        CH_UPPER_O: n_radix = RADIX_OCT;
                        CH_UPPER_B: n_radix = RADIX_BIN;
                        default: begin
                            // no prefix: the byte goes on as a plain number
                            n_len      = r_len;
                            n_acc      = r_acc;
                            n_seen     = r_seen;
                            w_num_path = 1'b1;
                        end
                    endcase
                end
                MODE_NUMBER: begin
                    w_num_path = 1'b1;
                end
                default: begin
                    w_relex = 1'b1;
                end
            endcase

            // number body: underscore, digit, bad digit, overflow or end
            if (w_num_path) begin
                if (i_source_byte == CH_UNDERSCORE) begin
                    n_len = r_len + PLEN_ONE;
                end else if (w_is_digit || w_is_letter) begin
                    if (w_dval >= w_base) begin
                        w_e0_vld = 1'b1;
                        w_e0 = mk_tok(KIND_BADNUM, r_start, r_len, 64'd0,
                                      r_seen ? NERR_BAD_DIGIT : NERR_NO_DIGITS);
                        w_relex = 1'b1;
                    end else if (w_overflow) begin
                        w_e0_vld = 1'b1;
                        w_e0 = mk_tok(KIND_BADNUM, r_start, r_len + PLEN_ONE, 64'd0,
                                      NERR_OVERFLOW);
                        n_mode = MODE_IDLE;
                    end else begin
                        n_len  = r_len + PLEN_ONE;
                        n_acc  = w_sum[63:0];
                        n_seen = 1'b1;
                    end
                end else begin
                    w_e0_vld = 1'b1;
                    if (r_seen) begin
                        w_e0 = mk_tok(KIND_NUMBER, r_start, r_len, r_acc, NERR_NONE);
                    end else begin
                        w_e0 = mk_tok(KIND_BADNUM, r_start, r_len, 64'd0, NERR_NO_DIGITS);
                    end
                    w_relex = 1'b1;
                end
            end

            // lex the byte afresh from idle
            if (w_relex) begin
                n_mode = MODE_IDLE;
                unique case (i_source_byte) inside
                    CH_SPACE, CH_TAB: begin
                    end
                    CH_COMMA: begin
                        w_e1_vld = 1'b1;
                        w_e1 = mk_tok(KIND_COMMA, r_pos, PLEN_ONE, 64'd0, NERR_NONE);
                    end
                    CH_MINUS: begin
                        w_e1_vld = 1'b1;
                        w_e1 = mk_tok(KIND_MINUS, r_pos, PLEN_ONE, 64'd0, NERR_NONE);
                    end
                    CH_DOT: begin
                        w_e1_vld = 1'b1;
                        w_e1 = mk_tok(KIND_DOT, r_pos, PLEN_ONE, 64'd0, NERR_NONE);
                    end
                    CH_COLON: begin
                        w_e1_vld = 1'b1;
                        w_e1 = mk_tok(KIND_COLON, r_pos, PLEN_ONE, 64'd0, NERR_NONE);
                    end
                    CH_LF: begin
                        w_e1_vld = 1'b1;
                        w_e1 = mk_tok(KIND_NEWLINE, r_pos, PLEN_ONE, 64'd0, NERR_NONE);
                    end
                    CH_CR: begin
                        n_mode  = MODE_CR;
                        n_start = r_pos;
                        n_len   = PLEN_ONE;
                    end
                    CH_SEMI: begin
                        n_mode  = MODE_COMMENT;
                        n_start = r_pos;
                        n_len   = PLEN_ONE;
                    end
                    default: begin
                        if (w_is_digit) begin
                            n_mode  = (i_source_byte == CH_ZERO) ? MODE_ZERO : MODE_NUMBER;
                            n_start = r_pos;
                            n_len   = PLEN_ONE;
                            n_acc   = 64'(w_dval);
                            n_radix = RADIX_DEC;
                            n_seen  = 1'b1;
                        end else if (w_is_ident) begin
                            n_mode  = MODE_IDENT;
                            n_start = r_pos;
                            n_len   = PLEN_ONE;
                        end else begin
                            w_e1_vld = 1'b1;
                            w_e1 = mk_tok(KIND_INVALID, r_pos, PLEN_ONE, 64'd0, NERR_NONE);
                        end
                    end
                endcase
            end
        end
    end

    // Pack the tokens in order and mark the final one
    always_comb begin
        o_push.count  = {1'b0, w_e0_vld} + {1'b0, w_e1_vld};
        o_push.first  = w_e0_vld ? w_e0 : w_e1;
        o_push.second = w_e1;
        if (w_e0_vld && w_e1_vld) begin
            o_push.second.last = 1'b1;
        end else begin
            o_push.first.last = 1'b1;
        end
    end

    // Hold scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_start <= PLEN_ZERO;
            r_len   <= PLEN_ZERO;
            r_pos   <= PLEN_ZERO;
            r_acc   <= 64'd0;
            r_radix <= RADIX_DEC;
            r_seen  <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_radix <= n_radix;
            r_seen  <= n_seen;
        end
    end

endmodule

// ----- hdl/atl_token_fifo.sv -----
// ----------------------------------------------------------------------------
// atl_token_fifo
// Small token queue between the lexer core and the output port. Takes up to
// two tokens per cycle and delivers one per output beat.
// ----------------------------------------------------------------------------
module atl_token_fifo
    import atl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_stall,
    output logic   o_valid,
    output t_token o_head,
    output logic   o_room
);

    localparam int AW = $clog2(TOKEN_FIFO_DEPTH);
    localparam int CW = $clog2(TOKEN_FIFO_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(TOKEN_FIFO_DEPTH - 1);
    localparam logic [CW-1:0] ROOM_MAX = CW'(TOKEN_FIFO_DEPTH - 2);

    t_token        r_mem [TOKEN_FIFO_DEPTH];
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] w_wp1;
    logic          w_pop;
    logic [CW-1:0] w_after_pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + AW'(1);
    endfunction

    assign o_valid     = (r_count != '0);
    assign o_head      = r_mem[r_rp];
    assign w_pop       = o_valid && !i_stall;
    assign w_after_pop = r_count - CW'(w_pop);
    // room for two more tokens once this cycle's beat leaves
    assign o_room      = (w_after_pop <= ROOM_MAX);
    assign w_wp1       = ptr_inc(r_wp);

    // Advance pointers and fill count
    always_comb begin
        n_rp    = w_pop ? ptr_inc(r_rp) : r_rp;
        n_count = w_after_pop + CW'(i_push.count);
        case (i_push.count)
            2'd1:    n_wp = w_wp1;
            2'd2:    n_wp = ptr_inc(w_wp1);
            default: n_wp = r_wp;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Write up to two entries
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TOKEN_FIFO_DEPTH; i++) begin
            if (i_push.count != 2'd0 && AW'(i) == r_wp) begin
                r_mem[i] <= i_push.first;
            end
            if (i_push.count == 2'd2 && AW'(i) == w_wp1) begin
                r_mem[i] <= i_push.second;
            end
        end
    end

endmodule

// ----- dv/tb_assembler_token_lexer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_assembler_token_lexer
// Self-checking bench for the assembly token lexer. A short table of
// directed bytes comes first: punctuation, newlines, comments, prefixes and
// number errors. Random source text follows: words that are mostly
// well-formed, mixed with noise and end-of-input beats. Every output token is
// compared field by field with a cycle-free lexer model or a table token. Both
// sides idle in random bursts, and the token side holds off once for a long
// stretch so that the output queue fills and the byte side stalls.
// ----------------------------------------------------------------------------
module tb_assembler_token_lexer
    import atl_pkg::*;
;

    localparam int CLK_HIGH_NS   = 6;
    localparam int CLK_LOW_NS    = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 750;
    localparam int HOLD_AT_ITEM  = 300;
    localparam int QUIET_AT_ITEM = 650;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_CYCLES    = 300000;
    localparam int MAX_REPORTS   = 10;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_IDENT, SCAN_ZERO, SCAN_NUMBER, SCAN_COMMENT, SCAN_CR
    } t_scan;

    typedef enum logic [1:0] {
        RADIX_DEC, RADIX_HEX, RADIX_OCT, RADIX_BIN
    } t_radix;

    typedef struct {
        bit         cmd;
        logic [7:0] data;
        bit         typed;
        t_token     tok;
    } t_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        i_command     = 1'b0;
    logic [7:0]  i_source_byte = 8'h00;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [3:0]  o_token_kind;
    logic [31:0] o_token_start;
    logic [31:0] o_token_length;
    logic [63:0] o_number_value;
    logic [1:0]  o_number_error;
    logic        o_last_result;

    // Model state of the lexer
    t_scan       scan;
    logic [31:0] tok_start;
    logic [31:0] tok_len;
    logic [31:0] src_pos;
    logic [63:0] num_acc;
    t_radix      num_radix;
    bit          num_digits;
    t_token      step_tok [2];
    int          step_n;

    t_token      tokens_due [$];
    logic [8:0]  src_beats [$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          idle_on     = 1'b1;
    bit          hold_req    = 1'b0;
    bit          hold_done   = 1'b0;

    // Clock
    always begin
        #CLK_LOW_NS  i_clk = 1'b1;
        #CLK_HIGH_NS i_clk = 1'b0;
    end

    assembler_token_lexer #(
        .POSITION_BITS(32)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_source_byte  (i_source_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_number_value (o_number_value),
        .o_number_error (o_number_error),
        .o_last_result  (o_last_result)
    );

    function automatic t_token make_token(t_kind k, logic [31:0] s, logic [31:0] l,
                                          logic [63:0] v, t_num_err e, logic last);
        t_token t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        t.value  = v;
        t.err    = e;
        t.last   = last;
        return t;
    endfunction

    function automatic t_row table_row(bit cmd, logic [7:0] data, bit typed, t_token tok);
        t_row r;
        r.cmd   = cmd;
        r.data  = data;
        r.typed = typed;
        r.tok   = tok;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------
    function automatic void lexer_clear();
        scan       = SCAN_IDLE;
        tok_start  = '0;
        tok_len    = '0;
        src_pos    = '0;
        num_acc    = '0;
        num_radix  = RADIX_DEC;
        num_digits = 1'b0;
    endfunction

    function automatic void put_token(t_kind k, logic [31:0] s, logic [31:0] l,
                                      logic [63:0] v, t_num_err e);
        if (step_n < 2) begin
            step_tok[step_n] = make_token(k, s, l, v, e, 1'b0);
            step_n++;
        end
    endfunction

    function automatic bit is_letter(logic [7:0] b);
        return ((b & 8'hDF) >= "A") && ((b & 8'hDF) <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic [63:0] radix_base(t_radix r);
        case (r)
            RADIX_HEX: return 64'd16;
            RADIX_OCT: return 64'd8;
            RADIX_BIN: return 64'd2;
            default:   return 64'd10;
        endcase
    endfunction

    function automatic void open_token(t_scan m, logic [31:0] p);
        scan      = m;
        tok_start = p;
        tok_len   = 32'd1;
    endfunction

    function automatic void close_number();
        if (num_digits) begin
            put_token(KIND_NUMBER, tok_start, tok_len, num_acc, NERR_NONE);
        end else begin
            put_token(KIND_BADNUM, tok_start, tok_len, '0, NERR_NO_DIGITS);
        end
        scan = SCAN_IDLE;
    endfunction

    function automatic void flush_token();
        case (scan)
            SCAN_IDENT:   put_token(KIND_IDENT, tok_start, tok_len, '0, NERR_NONE);
            SCAN_ZERO,
            SCAN_NUMBER:  close_number();
            SCAN_COMMENT: put_token(KIND_COMMENT, tok_start, tok_len, '0, NERR_NONE);
            SCAN_CR:      put_token(KIND_NEWLINE, tok_start, 32'd1, '0, NERR_NONE);
            default: ;
        endcase
        scan = SCAN_IDLE;
    endfunction

    // Lex a byte with nothing pending
    function automatic void lex_fresh(logic [7:0] b, logic [31:0] p);
        case (b)
            CH_SPACE, CH_TAB: ;
            ",":   put_token(KIND_COMMA, p, 32'd1, '0, NERR_NONE);
            "-":   put_token(KIND_MINUS, p, 32'd1, '0, NERR_NONE);
            ".":   put_token(KIND_DOT, p, 32'd1, '0, NERR_NONE);
            ":":   put_token(KIND_COLON, p, 32'd1, '0, NERR_NONE);
            CH_LF: put_token(KIND_NEWLINE, p, 32'd1, '0, NERR_NONE);
            CH_CR: open_token(SCAN_CR, p);
            ";":   open_token(SCAN_COMMENT, p);
            default: begin
                if (is_digit(b)) begin
                    open_token((b == "0") ? SCAN_ZERO : SCAN_NUMBER, p);
                    num_acc    = 64'(b - 8'h30);
                    num_radix  = RADIX_DEC;
                    num_digits = 1'b1;
                end else if (b == "_" || is_letter(b)) begin
                    open_token(SCAN_IDENT, p);
                end else begin
                    put_token(KIND_INVALID, p, 32'd1, '0, NERR_NONE);
                end
            end
        endcase
    endfunction

    // Feed a byte to a pending number; returns 1 when the number keeps it
    function automatic bit number_take(logic [7:0] b);
        logic [63:0] base;
        logic [63:0] dv;
        logic [63:0] lim;
        base = radix_base(num_radix);
        if (b == "_") begin
            tok_len = tok_len + 32'd1;
            return 1'b1;
        end
        if (is_digit(b)) begin
            dv = 64'(b - 8'h30);
        end else if (is_letter(b)) begin
            dv = 64'((b & 8'hDF) - 8'h37);
        end else begin
            close_number();
            return 1'b0;
        end
        // Digit too big for the base: drop it from the token
        if (dv >= base) begin
            put_token(KIND_BADNUM, tok_start, tok_len, '0,
                      num_digits ? NERR_BAD_DIGIT : NERR_NO_DIGITS);
            scan = SCAN_IDLE;
            return 1'b0;
        end
        tok_len = tok_len + 32'd1;
        // Overflow: the offending digit stays in the token
        lim = (64'hFFFF_FFFF_FFFF_FFFF - dv) / base;
        if (num_acc > lim) begin
            put_token(KIND_BADNUM, tok_start, tok_len, '0, NERR_OVERFLOW);
            scan = SCAN_IDLE;
            return 1'b1;
        end
        num_acc    = num_acc * base + dv;
        num_digits = 1'b1;
        return 1'b1;
    endfunction

    function automatic void lex_byte(logic [7:0] b, logic [31:0] p);
        bit prefix;
        case (scan)
            SCAN_IDENT: begin
                if (b == "_" || is_digit(b) || is_letter(b)) begin
                    tok_len = tok_len + 32'd1;
                    return;
                end
                put_token(KIND_IDENT, tok_start, tok_len, '0, NERR_NONE);
                scan = SCAN_IDLE;
            end
            SCAN_COMMENT: begin
                if (b != CH_LF && b != CH_CR) begin
                    tok_len = tok_len + 32'd1;
                    return;
                end
                put_token(KIND_COMMENT, tok_start, tok_len, '0, NERR_NONE);
                scan = SCAN_IDLE;
            end
            SCAN_CR: begin
                scan = SCAN_IDLE;
                if (b == CH_LF) begin
                    put_token(KIND_NEWLINE, tok_start, 32'd2, '0, NERR_NONE);
                    return;
                end
                put_token(KIND_NEWLINE, tok_start, 32'd1, '0, NERR_NONE);
            end
            SCAN_ZERO: begin
                // A leading zero may be followed by a base prefix letter
                prefix = 1'b1;
                case (b & 8'hDF)
                    "X":     num_radix = RADIX_HEX;
                    "D":     num_radix = RADIX_DEC;
                    "O":     num_radix = RADIX_OCT;
                    "B":     num_radix = RADIX_BIN;
                    default: prefix = 1'b0;
                endcase
                scan = SCAN_NUMBER;
                if (prefix) begin
                    tok_len    = 32'd2;
                    num_acc    = '0;
                    num_digits = 1'b0;
                    return;
                end
                if (number_take(b)) return;
            end
            SCAN_NUMBER: begin
                if (number_take(b)) return;
            end
            default: scan = SCAN_IDLE;
        endcase
        lex_fresh(b, p);
    endfunction

    // Tokens caused by one input beat
    function automatic void lex_step(bit cmd, logic [7:0] b);
        step_n = 0;
        if (cmd) begin
            flush_token();
            put_token(KIND_EOF, src_pos, 32'd0, '0, NERR_NONE);
            lexer_clear();
        end else begin
            lex_byte(b, src_pos);
            src_pos = src_pos + 32'd1;
        end
        if (step_n > 0) step_tok[step_n - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Random source text
    // ------------------------------------------------------------------
    function automatic void push_byte(logic [7:0] c);
        src_beats.push_back({1'b0, c});
    endfunction

    function automatic logic [7:0] any_case(logic [7:0] c);
        return $urandom_range(0, 1) ? (c | CASE_BIT) : c;
    endfunction

    function automatic logic [7:0] digit_char(int v);
        if (v < 10) return 8'(8'h30 + v);
        return any_case(8'(8'h41 + v - 10));
    endfunction

    function automatic void compose_number();
        int sel;
        int radix_n;
        int n;
        sel = $urandom_range(0, 4);
        case (sel)
            1:       radix_n = 16;
            3:       radix_n = 8;
            4:       radix_n = 2;
            default: radix_n = 10;
        endcase
        if (sel != 0) begin
            push_byte("0");
            case (sel)
                1:       push_byte(any_case("X"));
                2:       push_byte(any_case("D"));
                3:       push_byte(any_case("O"));
                default: push_byte(any_case("B"));
            endcase
        end
        // Mostly short runs, now and then one long enough to overflow
        if ($urandom_range(0, 9) == 0) begin
            case (radix_n)
                16:      n = $urandom_range(15, 18);
                8:       n = $urandom_range(20, 23);
                2:       n = $urandom_range(62, 66);
                default: n = $urandom_range(19, 21);
            endcase
        end else begin
            n = $urandom_range((sel == 0) ? 1 : 0, 5);
        end
        for (int k = 0; k < n; k++) begin
            if (k > 0 && $urandom_range(0, 7) == 0) push_byte("_");
            push_byte(digit_char($urandom_range(0, radix_n - 1)));
        end
        if ($urandom_range(0, 7) == 0) push_byte(digit_char($urandom_range(radix_n, 35)));
    endfunction

    function automatic void compose_word();
        int pick;
        int n;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            // identifier
            push_byte(($urandom_range(0, 5) == 0) ? "_" : any_case(8'(8'h41 + $urandom_range(0, 25))));
            n = $urandom_range(0, 8);
            repeat (n) begin
                case ($urandom_range(0, 3))
                    0:       push_byte("_");
                    1:       push_byte(digit_char($urandom_range(0, 9)));
                    default: push_byte(digit_char($urandom_range(10, 35)));
                endcase
            end
        end else if (pick < 50) begin
            compose_number();
        end else if (pick < 62) begin
            case ($urandom_range(0, 3))
                0:       push_byte(",");
                1:       push_byte("-");
                2:       push_byte(".");
                default: push_byte(":");
            endcase
        end else if (pick < 70) begin
            case ($urandom_range(0, 2))
                0: push_byte(CH_LF);
                1: begin
                    push_byte(CH_CR);
                    push_byte(CH_LF);
                end
                default: push_byte(CH_CR);
            endcase
        end else if (pick < 76) begin
            // comment, closed by a line end
            push_byte(";");
            n = $urandom_range(0, 10);
            repeat (n) begin
                c = 8'($urandom_range(0, 255));
                push_byte((c == CH_LF || c == CH_CR) ? "x" : c);
            end
            push_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
        end else if (pick < 90) begin
            n = $urandom_range(1, 3);
            repeat (n) push_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            return;
        end else if (pick < 97) begin
            n = $urandom_range(1, 2);
            repeat (n) push_byte(8'($urandom_range(0, 255)));
        end else begin
            src_beats.push_back({1'b1, 8'($urandom_range(0, 255))});
            return;
        end
        // Separate most words; the rest run into each other
        if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 3))
                0:       push_byte(CH_SPACE);
                1:       push_byte(CH_TAB);
                2:       push_byte(",");
                default: push_byte(CH_LF);
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte side: drive one beat, starting and ending at a falling edge
    // ------------------------------------------------------------------
    task automatic send_beat(bit cmd, logic [7:0] data, bit typed, t_token typed_tok);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        lex_step(cmd, data);
        if (typed) begin
            tokens_due.push_back(typed_tok);
        end else begin
            for (int k = 0; k < step_n; k++) tokens_due.push_back(step_tok[k]);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_source_byte <= data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Token side: random stall bursts plus one long hold-off
    // ------------------------------------------------------------------
    initial begin : token_sink
        int span;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                span = $urandom_range(1, 9);
                i_stall <= 1'b1;
                repeat (span - 1) @(negedge i_clk);
            end else begin
                span = $urandom_range(1, 8);
                i_stall <= 1'b0;
                repeat (span - 1) @(negedge i_clk);
            end
        end
    end

    task automatic report_mismatch(string what, t_token want, t_token got);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t %s: expected kind=%0d start=%0d len=%0d value=%0h err=%0d last=%0d",
                     $time, what, want.kind, want.start, want.length, want.value,
                     want.err, want.last);
            $display("    got kind=%0d start=%0d len=%0d value=%0h err=%0d last=%0d",
                     got.kind, got.start, got.length, got.value, got.err, got.last);
        end
    endtask

    // Compare each output beat against the oldest predicted token
    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = make_token(t_kind'(o_token_kind), o_token_start, o_token_length,
                             o_number_value, t_num_err'(o_number_error), o_last_result);
            if (tokens_due.size() == 0) begin
                report_mismatch("token with none due", '0, got);
            end else begin
                want = tokens_due.pop_front();
                if (got.kind !== want.kind || got.start !== want.start ||
                    got.length !== want.length || got.value !== want.value ||
                    got.err !== want.err || got.last !== want.last) begin
                    report_mismatch("token mismatch", want, got);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_row       rows [$];
        string      boundary_words [5];
        logic [8:0] beat;
        int         sent;

        lexer_clear();
        boundary_words = '{"0x1_0000_0000_0000_0000 ", "0xFFFF_FFFF_FFFF_FFFF,",
                           "18446744073709551615 ", "18446744073709551616:",
                           "-9223372036854775808;"};

        // End of input straight after reset
        rows.push_back(table_row(1'b1, 8'h00, 1'b1,
                       make_token(KIND_EOF, 32'd0, 32'd0, '0, NERR_NONE, 1'b1)));
        // One-byte tokens and separators
        rows.push_back(table_row(1'b0, ",", 1'b1,
                       make_token(KIND_COMMA, 32'd0, 32'd1, '0, NERR_NONE, 1'b1)));
        rows.push_back(table_row(1'b0, "-", 1'b0, '0));
        rows.push_back(table_row(1'b0, ".", 1'b0, '0));
        rows.push_back(table_row(1'b0, ":", 1'b0, '0));
        rows.push_back(table_row(1'b0, CH_SPACE, 1'b0, '0));
        rows.push_back(table_row(1'b0, CH_TAB, 1'b0, '0));
        // Byte extremes are invalid tokens
        rows.push_back(table_row(1'b0, 8'h00, 1'b1,
                       make_token(KIND_INVALID, 32'd6, 32'd1, '0, NERR_NONE, 1'b1)));
        rows.push_back(table_row(1'b0, 8'hFF, 1'b1,
                       make_token(KIND_INVALID, 32'd7, 32'd1, '0, NERR_NONE, 1'b1)));
        // CRLF, lone CR cut by a comment, comment closed by LF
        rows.push_back(table_row(1'b0, CH_CR, 1'b0, '0));
        rows.push_back(table_row(1'b0, CH_LF, 1'b0, '0));
        rows.push_back(table_row(1'b0, CH_CR, 1'b0, '0));
        rows.push_back(table_row(1'b0, ";", 1'b0, '0));
        rows.push_back(table_row(1'b0, CH_LF, 1'b0, '0));
        // Binary prefix with no digits, then a decimal with a bad digit
        rows.push_back(table_row(1'b0, "0", 1'b0, '0));
        rows.push_back(table_row(1'b0, "B", 1'b0, '0));
        rows.push_back(table_row(1'b0, "2", 1'b1,
                       make_token(KIND_BADNUM, 32'd13, 32'd2, '0, NERR_NO_DIGITS, 1'b1)));
        rows.push_back(table_row(1'b0, "a", 1'b1,
                       make_token(KIND_BADNUM, 32'd15, 32'd1, '0, NERR_BAD_DIGIT, 1'b1)));
        // Identifier ended by the byte just below the upper-case letters
        rows.push_back(table_row(1'b0, "9", 1'b0, '0));
        rows.push_back(table_row(1'b0, "_", 1'b0, '0));
        rows.push_back(table_row(1'b0, "@", 1'b0, '0));
        // Hex number with an underscore, flushed by end of input
        rows.push_back(table_row(1'b0, "0", 1'b0, '0));
        rows.push_back(table_row(1'b0, "x", 1'b0, '0));
        rows.push_back(table_row(1'b0, "_", 1'b0, '0));
        rows.push_back(table_row(1'b0, "f", 1'b0, '0));
        rows.push_back(table_row(1'b1, 8'hA5, 1'b0, '0));

        // Hold reset, release at a falling edge
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) send_beat(rows[i].cmd, rows[i].data, rows[i].typed, rows[i].tok);

        // Random text, boundary numbers first
        foreach (boundary_words[w]) begin
            for (int k = 0; k < boundary_words[w].len(); k++) push_byte(boundary_words[w][k]);
        end
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (src_beats.size() == 0) compose_word();
            beat = src_beats.pop_front();
            send_beat(beat[8], beat[7:0], 1'b0, '0);
            sent++;
            if (sent >= HOLD_AT_ITEM) hold_req = 1'b1;
            if (sent >= QUIET_AT_ITEM) idle_on = 1'b0;
        end
        // Flush whatever is pending
        send_beat(1'b1, 8'h00, 1'b0, '0);
        i_valid <= 1'b0;

        // Drain and finish
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
